/* hw/rtl/afrd_pkg.sv */
package afrd_pkg;

  // Framing bytes and checksum base.
  localparam logic [7:0] DELIM    = 8'h7E;
  localparam logic [7:0] ESC_MARK = 8'h7D;
  localparam logic [7:0] ESC_XOR  = 8'h20;
  localparam logic [7:0] SUM_BASE = 8'hFF;

  // Receive phase, one-hot.
  typedef enum logic [4:0] {
    PH_HUNT   = 5'b00001,
    PH_LEN_HI = 5'b00010,
    PH_LEN_LO = 5'b00100,
    PH_DATA   = 5'b01000,
    PH_CHECK  = 5'b10000
  } phase_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  // One result word.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        first;
    logic [15:0] len;
  } res_t;

  // Result push from the deframer core to the output buffer.
  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

endpackage

/* hw/rtl/afrd_core.sv */
module afrd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_escape,
  input  logic            in_accept,
  input  logic [7:0]      in_rx_byte,
  output afrd_pkg::push_t push
);

  afrd_pkg::phase_t phase_r, phase_nxt;
  logic             pend_r, pend_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [15:0]      seen_r, seen_nxt;
  logic [7:0]       sum_r, sum_nxt;

  logic             pend;
  logic             use_byte;
  logic [7:0]       b;
  logic [15:0]      seen_inc;
  afrd_pkg::res_t   res;
  logic             emit;

  assign pend     = cfg_escape & pend_r;
  assign seen_inc = seen_r + 16'd1;

  // Unescape the raw byte and work out whether it reaches the phase logic.
  always_comb begin
    b        = in_rx_byte;
    use_byte = 1'b1;
    pend_nxt = pend;
    if (cfg_escape) begin
      if (pend) begin
        b        = in_rx_byte ^ afrd_pkg::ESC_XOR;
        pend_nxt = 1'b0;
      end else if (in_rx_byte == afrd_pkg::ESC_MARK) begin
        use_byte = 1'b0;
        pend_nxt = 1'b1;
      end
    end
    if (cfg_escape && in_rx_byte == afrd_pkg::DELIM) begin
      use_byte = 1'b0;
    end
  end

  // Phase sequencing and result formation for one word.
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    sum_nxt   = sum_r;
    emit      = 1'b0;
    res.kind  = afrd_pkg::KIND_PAYLOAD;
    res.data  = b;
    res.first = 1'b0;
    res.len   = len_r;
    unique case (phase_r)
      afrd_pkg::PH_LEN_HI, afrd_pkg::PH_LEN_LO, afrd_pkg::PH_DATA,
      afrd_pkg::PH_CHECK: begin
        if (cfg_escape && in_rx_byte == afrd_pkg::DELIM) begin
          // With escaping on, a raw delimiter inside the frame restarts it.
          phase_nxt = afrd_pkg::PH_LEN_HI;
          len_nxt   = '0;
          seen_nxt  = '0;
          sum_nxt   = '0;
        end else if (use_byte) begin
          unique case (phase_r)
            afrd_pkg::PH_LEN_HI: begin
              len_nxt   = {b, 8'h00};
              phase_nxt = afrd_pkg::PH_LEN_LO;
            end
            afrd_pkg::PH_LEN_LO: begin
              len_nxt   = {len_r[15:8], b};
              seen_nxt  = '0;
              sum_nxt   = '0;
              phase_nxt = ({len_r[15:8], b} == 16'd0) ? afrd_pkg::PH_CHECK
                                                       : afrd_pkg::PH_DATA;
            end
            afrd_pkg::PH_DATA: begin
              emit      = 1'b1;
              res.first = (seen_r == 16'd0);
              sum_nxt   = sum_r + b;
              seen_nxt  = seen_inc;
              if (seen_inc >= len_r) begin
                phase_nxt = afrd_pkg::PH_CHECK;
              end
            end
            default: begin
              // Checksum byte: good when it equals the base minus the sum.
              emit      = 1'b1;
              res.kind  = (b == (afrd_pkg::SUM_BASE - sum_r)) ? afrd_pkg::KIND_GOOD
                                                              : afrd_pkg::KIND_BAD;
              phase_nxt = afrd_pkg::PH_HUNT;
              seen_nxt  = '0;
              sum_nxt   = '0;
            end
          endcase
        end
      end
      default: begin
        // Hunting, and any code without meaning: wait for a delimiter.
        if (in_rx_byte == afrd_pkg::DELIM) begin
          phase_nxt = afrd_pkg::PH_LEN_HI;
          len_nxt   = '0;
          seen_nxt  = '0;
          sum_nxt   = '0;
        end else begin
          phase_nxt = afrd_pkg::PH_HUNT;
        end
      end
    endcase
  end

  // The pending escape clears on a delimiter and at the checksum byte.
  logic pend_final;
  always_comb begin
    pend_final = pend_nxt;
    if (phase_r == afrd_pkg::PH_HUNT || !(phase_r == afrd_pkg::PH_LEN_HI ||
        phase_r == afrd_pkg::PH_LEN_LO || phase_r == afrd_pkg::PH_DATA ||
        phase_r == afrd_pkg::PH_CHECK)) begin
      pend_final = (in_rx_byte == afrd_pkg::DELIM) ? 1'b0 : pend;
    end else if (cfg_escape && in_rx_byte == afrd_pkg::DELIM) begin
      pend_final = 1'b0;
    end else if (emit && phase_r == afrd_pkg::PH_CHECK) begin
      pend_final = 1'b0;
    end
  end

  // State registers advance only on an accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= afrd_pkg::PH_HUNT;
      pend_r  <= 1'b0;
      len_r   <= '0;
      seen_r  <= '0;
      sum_r   <= '0;
    end else if (in_accept) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_final;
      len_r   <= len_nxt;
      seen_r  <= seen_nxt;
      sum_r   <= sum_nxt;
    end
  end

  assign push.valid = in_accept & emit;
  assign push.res   = res;

  // Checks.
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("phase register is not one-hot");

  a_payload_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && push.res.kind == afrd_pkg::KIND_PAYLOAD) |->
      phase_r == afrd_pkg::PH_DATA)
    else $error("payload word emitted outside the data phase");

  a_check_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && phase_r == afrd_pkg::PH_CHECK && !cfg_escape) |=>
      phase_r == afrd_pkg::PH_HUNT)
    else $error("checksum byte did not return to hunting");

endmodule

/* hw/rtl/afrd_out_buf.sv */
module afrd_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  afrd_pkg::push_t push,
  output logic            can_push,
  output logic            out_valid,
  input  logic            out_ready,
  output afrd_pkg::res_t  head
);

  logic [1:0]     cnt_r, cnt_nxt;
  afrd_pkg::res_t e0_r, e0_nxt;
  afrd_pkg::res_t e1_r, e1_nxt;
  logic           pop;

  assign out_valid = (cnt_r != 2'd0);
  assign can_push  = (cnt_r != 2'd2);
  assign pop       = out_valid & out_ready;
  assign head      = e0_r;

  // Two-entry queue: head register plus a skid entry behind it.
  always_comb begin
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    cnt_nxt = cnt_r + {1'b0, push.valid} - {1'b0, pop};
    if (pop) begin
      e0_nxt = e1_r;
    end
    if (push.valid) begin
      if ((cnt_r - {1'b0, pop}) == 2'd0) begin
        e0_nxt = push.res;
      end else begin
        e1_nxt = push.res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  // Checks.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> can_push)
    else $error("push into a full output queue");

  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(e0_r))
    else $error("stalled head word changed");

endmodule

/* hw/rtl/api_frame_receive_deframer.sv */
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// in       | in_valid / in_ready  | in_rx_byte[7:0]
// out      | out_valid / out_ready| out_kind[1:0], out_out_byte[7:0],
//          |                      | out_first_of_frame, out_frame_length[15:0]
// cfg      | cfg_wr_en            | cfg_wr_data (escape enable)
//
// One received byte is taken per cycle while in_ready is high; a result word is
// registered into the output queue. Rate is set by the phase update of the
// deframer state registers. A two-entry output queue lets input continue while
// one result waits; in_ready drops only when both entries are held.
// Synchronous active-low reset returns the deframer to hunting, escaping off.
module api_frame_receive_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_out_byte,
  output logic        out_first_of_frame,
  output logic [15:0] out_frame_length
);

  logic            escape_r;
  logic            in_accept;
  afrd_pkg::push_t push;
  afrd_pkg::res_t  head;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r <= 1'b0;
    end else if (cfg_wr_en) begin
      escape_r <= cfg_wr_data;
    end
  end

  assign in_accept = in_valid & in_ready;

  afrd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_escape (escape_r),
    .in_accept  (in_accept),
    .in_rx_byte (in_rx_byte),
    .push       (push)
  );

  afrd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_kind           = head.kind;
  assign out_out_byte       = head.data;
  assign out_first_of_frame = head.first;
  assign out_frame_length   = head.len;

endmodule
